// ----- src/bpa_pkg.sv -----
// Shared constants and codes of the bitmap page allocator.
package bpa_pkg;

  // Map geometry; both counts are powers of two
  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = PAGE_COUNT / WORD_BITS;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IN_ADDR_W  = 32;
  localparam int unsigned PAGE_NUM_W = IN_ADDR_W - PAGE_SHIFT;
  localparam int unsigned BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int unsigned PAGE_IDX_W = WORD_IDX_W + BIT_IDX_W;
  localparam int unsigned OUT_ADDR_W = 24;
  localparam int unsigned STATUS_W   = 2;

  // Request kinds
  localparam logic KIND_FREE  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ----- src/bitmap_page_allocator.sv -----
// Bitmap page frame allocator: free-page bitmap in a synchronous RAM.
//
//  channel  | dir | word fields (low bit first)          | when
//  ---------+-----+---------------------------------------+------------------------------
//  s_axis   | in  | tuser: kind; tdata: page_address      | one request, free or alloc
//  m_axis   | out | tdata: alloc_address; tuser: status   | one result per request
//
// A free or an alloc that finds a page runs through accept, word read,
// modify and write back (the result is registered at write back).
// A free out of range or an alloc with the map empty ends at the word read step, where its result is registered.
// The RAM read latency and the read-modify-write of one map word set these steps.
// Reset clears the per-word valid and nonzero flags at once; a word never
// written reads as all zero, so no clearing pass runs.
// While the result register is full and not taken, the block holds in its
// last step; a new request is taken only in the idle state.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_ADDR_W-1:0]  s_axis_tdata,   // [31:0] page_address
  input  logic                  s_axis_tuser,   // [0] kind
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_ADDR_W-1:0] m_axis_tdata,   // [23:0] alloc_address
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  // one-hot word to the index of its set bit
  function automatic logic [BIT_IDX_W-1:0] enc_word(input logic [WORD_BITS-1:0] oh);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        idx = idx | BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [WORD_IDX_W-1:0] enc_map(input logic [MAP_WORDS-1:0] oh);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAP_WORDS; i++) begin
      if (oh[i]) begin
        idx = idx | WORD_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  logic [1:0]             state_q, state_d;
  logic                   kind_q;
  logic [PAGE_NUM_W-1:0]  page_q;
  logic [WORD_IDX_W-1:0]  widx_q, widx_d;
  logic [MAP_WORDS-1:0]   valid_q;   // word written since reset
  logic [MAP_WORDS-1:0]   nz_q;      // word holds a free page

  logic                   out_valid_q;
  logic [OUT_ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic                   out_load;
  logic                   out_free;

  // map RAM
  logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rdata_q;
  logic                   mem_re, mem_we;
  logic [WORD_BITS-1:0]   wdata;

  logic                   range_bad, map_empty;
  logic [MAP_WORDS-1:0]   nz_low;
  logic [WORD_IDX_W-1:0]  rd_idx;
  logic [WORD_BITS-1:0]   word_eff, word_low;
  logic [BIT_IDX_W-1:0]   alloc_bit;
  logic [PAGE_IDX_W-1:0]  alloc_page;
  logic [IN_ADDR_W-1:0]   alloc_full;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // read step: pick the word
  assign range_bad = (kind_q == KIND_FREE) && (page_q >= PAGE_NUM_W'(PAGE_COUNT));
  assign map_empty = (kind_q == KIND_ALLOC) && (nz_q == '0);
  assign nz_low    = nz_q & (~nz_q + MAP_WORDS'(1));
  assign rd_idx    = (kind_q == KIND_ALLOC) ? enc_map(nz_low) : page_q[BIT_IDX_W +: WORD_IDX_W];

  // modify step
  assign word_eff   = valid_q[widx_q] ? rdata_q : '0;
  assign word_low   = word_eff & (~word_eff + WORD_BITS'(1));
  assign alloc_bit  = enc_word(word_low);
  assign alloc_page = {widx_q, alloc_bit};
  assign alloc_full = IN_ADDR_W'(alloc_page) << PAGE_SHIFT;
  assign wdata      = (kind_q == KIND_ALLOC)
                      ? (word_eff & ~word_low)
                      : (word_eff | (WORD_BITS'(1) << page_q[BIT_IDX_W-1:0]));

  always_comb begin
    state_d      = state_q;
    widx_d       = widx_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_addr_d   = '0;
    out_status_d = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (range_bad || map_empty) begin
          out_status_d = range_bad ? ST_RANGE : ST_EMPTY;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          mem_re  = 1'b1;
          widx_d  = rd_idx;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (kind_q == KIND_ALLOC) begin
          out_addr_d = alloc_full[OUT_ADDR_W-1:0];
        end
        if (out_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[widx_q] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[widx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      nz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        valid_q[widx_q] <= 1'b1;
        nz_q[widx_q]    <= (wdata != '0);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q <= widx_d;
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      page_q <= s_axis_tdata[IN_ADDR_W-1:PAGE_SHIFT];
    end
    if (out_load) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  // RAM writes only close a read-modify-write
  a_we_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_MOD)
    else $error("map write outside modify step");

  // nonzero summary follows the word just written
  a_nz_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> nz_q[$past(widx_q)] == ($past(wdata) != '0))
    else $error("nonzero summary out of step with map word");

  // modify step is entered only from the read step
  a_mod_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_MOD) |-> $past(state_q) == S_READ)
    else $error("modify step without a word read");

  // an alloc that reaches the modify step always finds a free bit
  a_alloc_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && kind_q == KIND_ALLOC) |-> word_eff != '0)
    else $error("alloc read a word with no free page");

  // only a successful alloc carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_status_d != ST_OK) |-> out_addr_d == '0)
    else $error("failed request carries an address");

endmodule

// ----- tb/sv/bitmap_page_allocator_checker.sv -----
// Checker for the bitmap page allocator: predicts each result word and compares.
module bitmap_page_allocator_checker
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [IN_ADDR_W-1:0]  req_addr_i,
  input  logic                  req_kind_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_ADDR_W-1:0] res_addr_i,
  input  logic [STATUS_W-1:0]   res_status_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] alloc_address;
    logic [STATUS_W-1:0]   status;
  } page_result_t;

  // one bit per page, set = free
  logic [PAGE_COUNT-1:0] free_pages;
  page_result_t          outstanding_results[$];
  int                    fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = outstanding_results.size();

  function automatic page_result_t apply_page_request(input logic kind,
                                                      input logic [IN_ADDR_W-1:0] addr);
    page_result_t          res;
    logic [PAGE_NUM_W-1:0] page_num;
    logic [31:0]           byte_addr;
    bit                    found;
    res.alloc_address = '0;
    res.status        = ST_OK;
    page_num          = addr[IN_ADDR_W-1:PAGE_SHIFT];
    found             = 1'b0;
    if (kind == KIND_FREE) begin
      if (page_num >= PAGE_COUNT) res.status = ST_RANGE;
      else free_pages[page_num] = 1'b1;
    end else begin
      // lowest free page wins
      for (int p = 0; p < PAGE_COUNT && !found; p++) begin
        if (free_pages[p]) begin
          free_pages[p]     = 1'b0;
          byte_addr         = p << PAGE_SHIFT;
          res.alloc_address = byte_addr[OUT_ADDR_W-1:0];
          found             = 1'b1;
        end
      end
      if (!found) res.status = ST_EMPTY;
    end
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t want;
    if (!rst_ni) begin
      free_pages = '0;
      outstanding_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (outstanding_results.size() == 0) begin
          note_failure($sformatf("result word with nothing outstanding: addr %h status %0d",
                                 res_addr_i, res_status_i));
        end else begin
          want = outstanding_results.pop_front();
          if (want.alloc_address !== res_addr_i || want.status !== res_status_i)
            note_failure($sformatf("mismatch: addr exp %h got %h, status exp %0d got %0d",
                                   want.alloc_address, res_addr_i, want.status,
                                   res_status_i));
        end
      end
      if (req_valid_i && req_ready_i)
        outstanding_results.push_back(apply_page_request(req_kind_i, req_addr_i));
    end
  end

endmodule

// ----- tb/sv/tb_bitmap_page_allocator.sv -----
// Testbench top for the bitmap page allocator: clock, reset, stimulus and verdict.
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int TOTAL_WORDS = 870;     // directed plus random request words
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_ADDR_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = KIND_FREE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_ADDR_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  int fail_count;
  int outstanding;
  int words_sent  = 0;
  int cycle_count = 0;
  int ready_hold  = 0;
  bit steady_flow  = 1'b0;   // sender never idles while set
  bit steady_ready = 1'b0;   // receiver starts no new stall while set

  always #6 clk_i = ~clk_i;

  bitmap_page_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bitmap_page_allocator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_addr_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_addr_i   (m_axis_tdata),
    .res_status_i (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (outstanding)
  );

  // Receiver backpressure: mostly short stalls, now and then a long one.
  always @(posedge clk_i) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (steady_ready || r < 60) begin
        m_axis_tready <= 1'b1;
        ready_hold    = $urandom_range(0, 6);
      end else if (r < 93) begin
        m_axis_tready <= 1'b0;
        ready_hold    = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    = $urandom_range(10, 40);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int sender_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly in-range pages with junk in the offset bits; top word, first page
  // past the end and raw 32-bit values for the range check.
  function automatic logic [IN_ADDR_W-1:0] random_free_addr();
    int unsigned r;
    int unsigned page;
    r = $urandom_range(0, 99);
    if (r < 78) page = $urandom_range(0, PAGE_COUNT - 1);
    else if (r < 88) page = $urandom_range(PAGE_COUNT - WORD_BITS, PAGE_COUNT - 1);
    else if (r < 92) page = PAGE_COUNT;
    else return $urandom();
    return (page << PAGE_SHIFT) | $urandom_range(0, 4095);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input logic kind, input logic [IN_ADDR_W-1:0] addr);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Hold the sender until every result word is back; sampled at the falling
  // edge so the checker's update at the rising edge has settled.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int mode;
    int free_pct;
    int base;
    int n;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty map, idempotent and misaligned frees, range edges,
    // word boundaries, drain back to empty.
    send_word(KIND_ALLOC, 32'hFFFF_FFFF);   // nothing free yet
    send_word(KIND_FREE,  32'h0000_0000);
    send_word(KIND_FREE,  32'h0000_0FFF);   // same page again
    send_word(KIND_FREE,  32'h00FF_F000);   // last page
    send_word(KIND_FREE,  32'h00FF_FFFF);
    send_word(KIND_FREE,  32'h0100_0000);   // first page past the end
    send_word(KIND_FREE,  32'hFFFF_FFFF);
    send_word(KIND_FREE,  32'h8000_0000);
    send_word(KIND_FREE,  32'h0007_F123);   // page 127
    send_word(KIND_ALLOC, 32'h0000_0000);   // page 0
    send_word(KIND_ALLOC, 32'h5555_5555);   // page 127
    send_word(KIND_ALLOC, 32'hAAAA_AAAA);   // last page
    send_word(KIND_ALLOC, 32'hFFFF_FFFF);   // empty again
    send_word(KIND_ALLOC, 32'h0000_0000);
    send_word(KIND_FREE,  32'h0002_0000);   // page 32, first of word 1
    send_word(KIND_FREE,  32'h0001_F000);   // page 31, last of word 0
    send_word(KIND_ALLOC, 32'h1234_5678);
    send_word(KIND_ALLOC, 32'h8765_4321);
    send_word(KIND_FREE,  32'h00AB_CDEF);
    send_word(KIND_ALLOC, 32'h0000_0000);
    wait_drained();

    while (words_sent < TOTAL_WORDS) begin
      steady_flow  = ($urandom_range(0, 5) == 0);
      steady_ready = ($urandom_range(0, 5) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        // free a cluster of pages, then allocate them back and a bit more
        base = $urandom_range(0, PAGE_COUNT - 64);
        n    = $urandom_range(4, 24);
        repeat (n)
          send_word(KIND_FREE, ((base + $urandom_range(0, 63)) << PAGE_SHIFT)
                               | $urandom_range(0, 4095));
        repeat (n + $urandom_range(0, 3)) send_word(KIND_ALLOC, $urandom());
      end else begin
        free_pct = (mode < 7) ? 75 : ((mode < 9) ? 50 : 20);
        repeat (40) begin
          if ($urandom_range(0, 99) < free_pct) send_word(KIND_FREE, random_free_addr());
          else send_word(KIND_ALLOC, $urandom());
        end
      end
      if (!paused && words_sent > TOTAL_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
src/bpa_pkg.sv
src/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_checker.sv
tb/sv/tb_bitmap_page_allocator.sv
